// ===== hdl/multilevel_feedback_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler assertion macros
// Concurrent checks sampled on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// condition holds at every edge
`define MLFS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MLFS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared widths, codes and queue request types of the feedback scheduler.
// ----------------------------------------------------------------------------
package mlfs_pkg;

    localparam int DEFAULT_MAX_JOBS = 8;
    localparam int JOB_W            = 3;
    localparam int LEVEL_W          = 2;
    localparam int LIMIT_W          = 4;

    localparam logic [1:0] OP_ADMIT    = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_SLICE    = 2'd2;
    localparam logic [1:0] OP_FINISH   = 2'd3;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_IDLE   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    localparam logic [LEVEL_W-1:0] LV_HIGH   = 2'd0;
    localparam logic [LEVEL_W-1:0] LV_MEDIUM = 2'd1;
    localparam logic [LEVEL_W-1:0] LV_LOW    = 2'd2;

    localparam logic REG_HIGH_LIMIT   = 1'b0;
    localparam logic REG_MEDIUM_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET   = 4'd2;
    localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RESET = 4'd4;
    localparam logic [LIMIT_W-1:0] RUN_MAX            = 4'd15;

    typedef struct packed {
        logic               en;
        logic [LEVEL_W-1:0] lv;
        logic [JOB_W-1:0]   job;
    } push_t;

    typedef struct packed {
        logic               en;
        logic [LEVEL_W-1:0] lv;
    } pop_t;

endpackage

// ===== hdl/mlfs_queues.sv =====
// ----------------------------------------------------------------------------
// mlfs_queues
// Three job FIFOs sharing one synchronous memory, with head and count per level.
// ----------------------------------------------------------------------------
module mlfs_queues #(
    parameter int MAX_JOBS = mlfs_pkg::DEFAULT_MAX_JOBS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mlfs_pkg::push_t            push,
    input  mlfs_pkg::pop_t             pop,
    output logic [2:0]                 nonempty,
    output logic [mlfs_pkg::JOB_W-1:0] pop_job
);

    localparam int IW    = $clog2(MAX_JOBS);
    localparam int CW    = $clog2(MAX_JOBS + 1);
    localparam int DEPTH = 3 * (2 ** IW);

    logic [mlfs_pkg::JOB_W-1:0] mem [0:DEPTH-1];
    logic [mlfs_pkg::JOB_W-1:0] pop_job_reg;

    logic [IW-1:0] head_reg  [3];
    logic [IW-1:0] head_next [3];
    logic [CW-1:0] count_reg [3];
    logic [CW-1:0] count_next[3];

    logic [IW-1:0] sel_head;
    logic [CW-1:0] sel_count;
    logic [IW-1:0] pop_head;
    logic [IW:0]   tail_sum;
    logic [IW-1:0] tail;
    logic          push_ok;

    always_comb
    begin
        sel_head  = '0;
        sel_count = '0;
        pop_head  = '0;
        for (int l = 0; l < 3; l++)
        begin
            if (push.lv == 2'(l))
            begin
                sel_head  = head_reg[l];
                sel_count = count_reg[l];
            end
            if (pop.lv == 2'(l))
            begin
                pop_head = head_reg[l];
            end
        end

        tail_sum = {1'b0, sel_head} + (IW + 1)'(sel_count);
        if (tail_sum >= (IW + 1)'(MAX_JOBS))
            tail = IW'(tail_sum - (IW + 1)'(MAX_JOBS));
        else
            tail = IW'(tail_sum);

        push_ok = push.en && (push.lv <= mlfs_pkg::LV_LOW)
                  && (sel_count < CW'(MAX_JOBS));

        for (int l = 0; l < 3; l++)
        begin
            head_next[l]  = head_reg[l];
            count_next[l] = count_reg[l];
            if (push_ok && push.lv == 2'(l))
                count_next[l] = count_reg[l] + CW'(1);
            if (pop.en && pop.lv == 2'(l) && count_reg[l] != '0)
            begin
                if (head_reg[l] == IW'(MAX_JOBS - 1))
                    head_next[l] = '0;
                else
                    head_next[l] = head_reg[l] + IW'(1);
                count_next[l] = count_next[l] - CW'(1);
            end
            nonempty[l] = (count_reg[l] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < 3; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < 3; l++)
            begin
                head_reg[l]  <= head_next[l];
                count_reg[l] <= count_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[{push.lv, tail}] <= push.job;
        if (pop.en)
            pop_job_reg <= mem[{pop.lv, pop_head}];
    end

    assign pop_job = pop_job_reg;

endmodule

// ===== hdl/multilevel_feedback_scheduler.sv =====
// Admit, finish, reject and idle results are loaded straight into the output register.
// Dispatch and slice end first read the queue memory or the run-count memory, then load
// their result once the output slot is free; no new item is taken until then.
// Reset: rst_n clears queue pointers, active flags and running job, and restores both limits
// to their defaults at once; memory contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Three-level feedback job scheduler with per-job run counts in memory.
// ----------------------------------------------------------------------------
`include "multilevel_feedback_scheduler_assert.svh"

module multilevel_feedback_scheduler #(
    parameter int MAX_JOBS = mlfs_pkg::DEFAULT_MAX_JOBS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [1:0] opcode, [4:2] job, [7:5] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [1:0] status, [4:2] job_out, [6:5] level, [7] demoted
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int IW     = $clog2(MAX_JOBS);
    localparam int JW     = mlfs_pkg::JOB_W;
    localparam int LW     = mlfs_pkg::LEVEL_W;
    localparam int RW     = mlfs_pkg::LIMIT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POP   = 2'd1;
    localparam logic [1:0] ST_SLICE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [MAX_JOBS-1:0] active_reg, active_next;
    logic [JW-1:0]       running_job_reg, running_job_next;
    logic [LW-1:0]       running_level_reg, running_level_next;
    logic                running_valid_reg, running_valid_next;
    logic [LW-1:0]       dsp_lv_reg, dsp_lv_next;
    logic [RW-1:0]       high_limit_reg, medium_limit_reg;
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;

    logic [2*RW-1:0] runs_mem [0:MAX_JOBS-1];
    logic [2*RW-1:0] runs_rd_reg;

    mlfs_pkg::push_t push;
    mlfs_pkg::pop_t  pop;
    logic [2:0]      nonempty;
    logic [JW-1:0]   pop_job;

    logic [1:0]      in_opcode;
    logic [JW-1:0]   in_job;
    logic [IW-1:0]   admit_idx;
    logic [IW-1:0]   run_idx;
    logic            admit_bad;
    logic            accept;
    logic            slot_free;
    logic            pop_start;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [2*RW-1:0] mem_wdata;
    logic            mem_re;

    logic            out_load;
    logic [1:0]      o_status;
    logic [JW-1:0]   o_job;
    logic [LW-1:0]   o_level;
    logic            o_demoted;

    logic [RW-1:0]   high_runs, medium_runs, high_inc, medium_inc;
    logic [LW-1:0]   new_lv;
    logic            dem;

    mlfs_queues #(
        .MAX_JOBS (MAX_JOBS)
    ) u_queues (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .nonempty (nonempty),
        .pop_job  (pop_job)
    );

    assign in_opcode = s_tdata[1:0];
    assign in_job    = s_tdata[4:2];
    assign admit_idx = IW'(in_job);
    assign run_idx   = IW'(running_job_reg);
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign admit_bad = (32'(in_job) >= MAX_JOBS) || active_reg[admit_idx];
    assign cfg_ready = 1'b1;
    assign pop_start = accept && (in_opcode == mlfs_pkg::OP_DISPATCH) && !running_valid_reg
                       && (nonempty != 3'b000);

    assign high_runs   = runs_rd_reg[RW-1:0];
    assign medium_runs = runs_rd_reg[2*RW-1:RW];
    assign high_inc    = (high_runs == mlfs_pkg::RUN_MAX) ? high_runs : high_runs + RW'(1);
    assign medium_inc  = (medium_runs == mlfs_pkg::RUN_MAX) ? medium_runs
                                                            : medium_runs + RW'(1);

    always_comb
    begin
        new_lv = running_level_reg;
        dem    = 1'b0;
        case (running_level_reg)
            mlfs_pkg::LV_HIGH:
            begin
                if (high_inc >= high_limit_reg)
                begin
                    new_lv = mlfs_pkg::LV_MEDIUM;
                    dem    = 1'b1;
                end
            end
            mlfs_pkg::LV_MEDIUM:
            begin
                if (medium_inc >= medium_limit_reg)
                begin
                    new_lv = mlfs_pkg::LV_LOW;
                    dem    = 1'b1;
                end
            end
            default:
            begin
                new_lv = mlfs_pkg::LV_LOW;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        active_next        = active_reg;
        running_job_next   = running_job_reg;
        running_level_next = running_level_reg;
        running_valid_next = running_valid_reg;
        dsp_lv_next        = dsp_lv_reg;
        push               = '0;
        pop                = '0;
        mem_we             = 1'b0;
        mem_waddr          = run_idx;
        mem_wdata          = '0;
        mem_re             = 1'b0;
        out_load           = 1'b0;
        o_status           = mlfs_pkg::STATUS_REJECT;
        o_job              = '0;
        o_level            = '0;
        o_demoted          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    case (in_opcode)
                        mlfs_pkg::OP_ADMIT:
                        begin
                            if (!admit_bad)
                            begin
                                active_next[admit_idx] = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = admit_idx;
                                push.en   = 1'b1;
                                push.lv   = mlfs_pkg::LV_HIGH;
                                push.job  = in_job;
                                o_status  = mlfs_pkg::STATUS_DONE;
                                o_job     = in_job;
                            end
                        end
                        mlfs_pkg::OP_DISPATCH:
                        begin
                            if (!running_valid_reg)
                            begin
                                if (nonempty == 3'b000)
                                begin
                                    o_status = mlfs_pkg::STATUS_IDLE;
                                end
                                else
                                begin
                                    out_load = 1'b0;
                                    pop.en   = 1'b1;
                                    if (nonempty[0])
                                        pop.lv = mlfs_pkg::LV_HIGH;
                                    else if (nonempty[1])
                                        pop.lv = mlfs_pkg::LV_MEDIUM;
                                    else
                                        pop.lv = mlfs_pkg::LV_LOW;
                                    dsp_lv_next = pop.lv;
                                    state_next  = ST_POP;
                                end
                            end
                        end
                        mlfs_pkg::OP_SLICE:
                        begin
                            if (running_valid_reg)
                            begin
                                out_load   = 1'b0;
                                mem_re     = 1'b1;
                                state_next = ST_SLICE;
                            end
                        end
                        default:
                        begin
                            if (running_valid_reg)
                            begin
                                active_next[run_idx] = 1'b0;
                                running_valid_next   = 1'b0;
                                o_status = mlfs_pkg::STATUS_DONE;
                                o_job    = running_job_reg;
                                o_level  = running_level_reg;
                            end
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (slot_free)
                begin
                    running_job_next   = pop_job;
                    running_level_next = dsp_lv_reg;
                    running_valid_next = 1'b1;
                    out_load           = 1'b1;
                    o_status           = mlfs_pkg::STATUS_DONE;
                    o_job              = pop_job;
                    o_level            = dsp_lv_reg;
                    state_next         = ST_IDLE;
                end
            end
            ST_SLICE:
            begin
                if (slot_free)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = run_idx;
                    case (running_level_reg)
                        mlfs_pkg::LV_HIGH:   mem_wdata = {medium_runs, high_inc};
                        mlfs_pkg::LV_MEDIUM: mem_wdata = {medium_inc, high_runs};
                        default:             mem_wdata = runs_rd_reg;
                    endcase
                    push.en            = 1'b1;
                    push.lv            = new_lv;
                    push.job           = running_job_reg;
                    running_level_next = new_lv;
                    running_valid_next = 1'b0;
                    out_load           = 1'b1;
                    o_status           = mlfs_pkg::STATUS_DONE;
                    o_job              = running_job_reg;
                    o_level            = new_lv;
                    o_demoted          = dem;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            active_reg        <= '0;
            running_job_reg   <= '0;
            running_level_reg <= '0;
            running_valid_reg <= 1'b0;
            dsp_lv_reg        <= '0;
            out_valid_reg     <= 1'b0;
            high_limit_reg    <= mlfs_pkg::HIGH_LIMIT_RESET;
            medium_limit_reg  <= mlfs_pkg::MEDIUM_LIMIT_RESET;
        end
        else
        begin
            state_reg         <= state_next;
            active_reg        <= active_next;
            running_job_reg   <= running_job_next;
            running_level_reg <= running_level_next;
            running_valid_reg <= running_valid_next;
            dsp_lv_reg        <= dsp_lv_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mlfs_pkg::REG_HIGH_LIMIT)
                    high_limit_reg <= cfg_data;
                else
                    medium_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {o_demoted, o_level, o_job, o_status};
        if (mem_we)
            runs_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            runs_rd_reg <= runs_mem[run_idx];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `MLFS_ASSERT_IMPLY(a_run_active, running_valid_reg, active_reg[run_idx], "job not active")
    `MLFS_ASSERT_IMPLY(a_slice_job, state_reg == ST_SLICE, running_valid_reg, "no running job")
    `MLFS_ASSERT_NEXT(a_pop, pop_start, state_reg == ST_POP && !running_valid_reg, "no queue read")

endmodule
